FILE: rtl/cau_pkg.sv
`default_nettype none

package cau_pkg;

	// width of every operand and result port
	localparam int WORD_W = 32;

	// operation codes
	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	// control that travels with each beat down the pipeline
	typedef struct packed {
		logic valid;
		op_t  op;
		logic dz;
	} ctl_t;

endpackage

`default_nettype wire

FILE: rtl/complex_arithmetic_unit.sv
// Complex add, subtract, multiply and divide on signed fixed-point operands
// (DATA_WIDTH bits, FRAC_BITS fraction bits, taken from the low bits of each
// 32-bit port; results are sign-extended to 32 bits). One beat is accepted
// per cycle. The result beat passes through DATA_WIDTH+7 register stages:
// five front stages (products and sums, combining, sign/magnitude, dividend
// setup or rounding, clamp check), a row of DATA_WIDTH+1 restoring-division
// cells that each retire one quotient bit of both parts, and the output
// register. Multiply and divide round to nearest with ties away from zero;
// out-of-range results clamp and raise overflow; divide by zero gives zero
// and raises div_zero. The whole pipeline holds while a result waits on
// out_ready.
`default_nettype none

module complex_arithmetic_unit #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [31:0] a_real,
	input  wire logic [31:0] a_imag,
	input  wire logic [31:0] b_real,
	input  wire logic [31:0] b_imag,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      res_real,
	output logic [31:0]      res_imag,
	output logic             overflow,
	output logic             div_zero
);

	localparam int DW = DATA_WIDTH;
	localparam int RW = 2 * DW + 1;
	localparam int NC = DW + 1;
	localparam longint SAT_HI = (longint'(1) << (DW - 1)) - longint'(1);
	localparam longint SAT_LO = -(longint'(1) << (DW - 1));

	logic          en;
	cau_pkg::ctl_t ctl_in;

	// chain taps, index 0 is the front output
	cau_pkg::ctl_t             ctl_c [NC+1];
	logic [NC:0][2*DW-1:0]     d_c;
	logic [NC:0][1:0][RW-1:0]  r_c;
	logic [NC:0][1:0][DW:0]    n_c;
	logic [NC:0][1:0][DW:0]    q_c;
	logic [NC:0][1:0]          neg_c;
	logic [NC:0][1:0]          big_c;

	// pipeline moves whenever the output register can take a beat
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	assign ctl_in.valid = in_valid;
	assign ctl_in.op    = cau_pkg::op_t'(op);
	assign ctl_in.dz    = 1'b0;

	cau_front #(
		.DW (DW),
		.FB (FRAC_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_i  (ctl_in),
		.a_re   (a_real[DW-1:0]),
		.a_im   (a_imag[DW-1:0]),
		.b_re   (b_real[DW-1:0]),
		.b_im   (b_imag[DW-1:0]),
		.ctl_o  (ctl_c[0]),
		.d_o    (d_c[0]),
		.r_o    (r_c[0]),
		.n_o    (n_c[0]),
		.q_o    (q_c[0]),
		.neg_o  (neg_c[0]),
		.big_o  (big_c[0])
	);

	// one quotient bit per cell
	for (genvar i = 0; i < NC; i++) begin : g_cell
		cau_div_cell #(
			.DW (DW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_i  (ctl_c[i]),
			.d_i    (d_c[i]),
			.r_i    (r_c[i]),
			.n_i    (n_c[i]),
			.q_i    (q_c[i]),
			.neg_i  (neg_c[i]),
			.big_i  (big_c[i]),
			.ctl_o  (ctl_c[i+1]),
			.d_o    (d_c[i+1]),
			.r_o    (r_c[i+1]),
			.n_o    (n_c[i+1]),
			.q_o    (q_c[i+1]),
			.neg_o  (neg_c[i+1]),
			.big_o  (big_c[i+1])
		);
	end

	cau_back #(
		.DW (DW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.ctl_i     (ctl_c[NC]),
		.d_i       (d_c[NC]),
		.r_i       (r_c[NC]),
		.q_i       (q_c[NC]),
		.neg_i     (neg_c[NC]),
		.big_i     (big_c[NC]),
		.out_valid (out_valid),
		.res_real  (res_real),
		.res_imag  (res_imag),
		.overflow  (overflow),
		.div_zero  (div_zero)
	);

	// every dividend bit is consumed by the end of the row
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl_c[NC].valid && (ctl_c[NC].op == cau_pkg::OP_DIV) |-> (n_c[NC] == '0))
		else $error("dividend bits left over after last cell");

	// zero divisor gives a clean zero result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_zero |-> !overflow && (res_real == '0) && (res_imag == '0))
		else $error("divide by zero result not cleared");

	// results stay inside the data width
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(res_real) <= SAT_HI) && ($signed(res_real) >= SAT_LO) &&
		($signed(res_imag) <= SAT_HI) && ($signed(res_imag) >= SAT_LO))
		else $error("result outside data width");

	// overflow means at least one part sits on a bound
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |->
		($signed(res_real) == SAT_HI) || ($signed(res_real) == SAT_LO) ||
		($signed(res_imag) == SAT_HI) || ($signed(res_imag) == SAT_LO))
		else $error("overflow flagged on unclamped result");

endmodule

`default_nettype wire

FILE: rtl/cau_front.sv
`default_nettype none

module cau_front #(
	parameter int DW = 32,
	parameter int FB = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire cau_pkg::ctl_t         ctl_i,
	input  wire logic [DW-1:0]         a_re,
	input  wire logic [DW-1:0]         a_im,
	input  wire logic [DW-1:0]         b_re,
	input  wire logic [DW-1:0]         b_im,
	output cau_pkg::ctl_t              ctl_o,
	output logic [2*DW-1:0]            d_o,
	output logic [1:0][2*DW:0]         r_o,
	output logic [1:0][DW:0]           n_o,
	output logic [1:0][DW:0]           q_o,
	output logic [1:0]                 neg_o,
	output logic [1:0]                 big_o
);

	localparam int P  = 2 * DW;
	localparam int AW = ((P > DW + FB) ? P : DW + FB) + 1;
	localparam int RW = P + 1;
	localparam int NW = P + FB;
	localparam int TW = DW + FB - 1;
	localparam int CW = (TW > RW) ? TW : RW;
	localparam logic [AW:0] HALF = (FB > 0) ? ((AW+1)'(1) << ((FB > 0) ? FB - 1 : 0)) : '0;
	localparam logic [AW:0] LIMN = (AW+1)'(1) << (DW - 1);
	localparam logic [AW:0] LIMP = LIMN - (AW+1)'(1);

	logic signed [DW-1:0] ar, ai, br, bi;

	// stage 1 registers
	cau_pkg::ctl_t        ctl_s1;
	logic signed [P-1:0]  pp_rr_s1, pp_ii_s1, pp_ri_s1, pp_ir_s1, sq_r_s1, sq_i_s1;
	logic signed [DW:0]   sum_re_s1, sum_im_s1;

	// stage 2 registers
	cau_pkg::ctl_t        ctl_s2;
	logic signed [AW-1:0] acc_re_s2, acc_im_s2;
	logic [P-1:0]         d_s2;

	// stage 3 registers
	cau_pkg::ctl_t        ctl_s3;
	logic [1:0][AW-1:0]   mag_s3;
	logic [1:0]           neg_s3;
	logic [P-1:0]         d_s3;

	// stage 4 registers
	cau_pkg::ctl_t        ctl_s4;
	logic [1:0][RW-1:0]   r_s4;
	logic [1:0][DW:0]     n_s4;
	logic [1:0]           big_s4;
	logic [1:0][AW:0]     rmag_s4;
	logic [1:0]           neg_s4;
	logic [P-1:0]         d_s4;

	// stage 5 registers
	cau_pkg::ctl_t        ctl_s5;
	logic [1:0][RW-1:0]   r_s5;
	logic [1:0][DW:0]     n_s5;
	logic [1:0][DW:0]     q_s5;
	logic [1:0]           big_s5;
	logic [1:0]           neg_s5;
	logic [P-1:0]         d_s5;

	// stage 3 control with the zero divisor mark
	cau_pkg::ctl_t        ctl_flag;

	// stage 4 and 5 combinational terms
	logic [1:0][NW-1:0]   nfull;
	logic [1:0][CW-1:0]   top_ext;
	logic [1:0]           big_c;
	logic [1:0][AW:0]     rsum;
	logic [1:0][AW:0]     lim;
	logic [1:0]           sat;

	assign ar = a_re;
	assign ai = a_im;
	assign br = b_re;
	assign bi = b_im;

	// mark a divide with zero divisor
	always_comb begin
		ctl_flag    = ctl_s2;
		ctl_flag.dz = (ctl_s2.op == cau_pkg::OP_DIV) && (d_s2 == '0);
	end

	// control valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_flag;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	// stage 1: partial products and plain sums
	always_ff @(posedge clk) begin
		if (en) begin
			pp_rr_s1 <= ar * br;
			pp_ii_s1 <= ai * bi;
			pp_ri_s1 <= ar * bi;
			pp_ir_s1 <= ai * br;
			sq_r_s1  <= br * br;
			sq_i_s1  <= bi * bi;
			if (ctl_i.op == cau_pkg::OP_SUB) begin
				sum_re_s1 <= (DW+1)'(ar) - (DW+1)'(br);
				sum_im_s1 <= (DW+1)'(ai) - (DW+1)'(bi);
			end else begin
				sum_re_s1 <= (DW+1)'(ar) + (DW+1)'(br);
				sum_im_s1 <= (DW+1)'(ai) + (DW+1)'(bi);
			end
		end
	end

	// stage 2: combine products, scale plain sums, divisor
	always_ff @(posedge clk) begin
		if (en) begin
			d_s2 <= P'(sq_r_s1) + P'(sq_i_s1);
			unique case (ctl_s1.op)
				cau_pkg::OP_MUL: begin
					acc_re_s2 <= AW'(pp_rr_s1) - AW'(pp_ii_s1);
					acc_im_s2 <= AW'(pp_ri_s1) + AW'(pp_ir_s1);
				end
				cau_pkg::OP_DIV: begin
					acc_re_s2 <= AW'(pp_rr_s1) + AW'(pp_ii_s1);
					acc_im_s2 <= AW'(pp_ir_s1) - AW'(pp_ri_s1);
				end
				default: begin
					acc_re_s2 <= AW'(sum_re_s1) <<< FB;
					acc_im_s2 <= AW'(sum_im_s1) <<< FB;
				end
			endcase
		end
	end

	// stage 3: sign and magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s3[0] <= acc_re_s2[AW-1];
			neg_s3[1] <= acc_im_s2[AW-1];
			mag_s3[0] <= acc_re_s2[AW-1] ? AW'(-acc_re_s2) : AW'(acc_re_s2);
			mag_s3[1] <= acc_im_s2[AW-1] ? AW'(-acc_im_s2) : AW'(acc_im_s2);
			d_s3      <= d_s2;
		end
	end

	// stage 4: dividend setup and range check, or rounding
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			nfull[k]   = NW'(mag_s3[k][P-1:0]) << FB;
			top_ext[k] = CW'(nfull[k][NW-1:DW+1]);
			big_c[k]   = top_ext[k] >= CW'(d_s3);
			rsum[k]    = (AW+1)'(mag_s3[k]) + HALF;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 2; k++) begin
				r_s4[k]    <= top_ext[k][RW-1:0];
				n_s4[k]    <= nfull[k][DW:0];
				big_s4[k]  <= big_c[k];
				rmag_s4[k] <= rsum[k] >> FB;
			end
			neg_s4 <= neg_s3;
			d_s4   <= d_s3;
		end
	end

	// stage 5: clamp check for non-divide results
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			lim[k] = neg_s4[k] ? LIMN : LIMP;
			sat[k] = rmag_s4[k] > lim[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 2; k++) begin
				if (ctl_s4.op == cau_pkg::OP_DIV) begin
					q_s5[k]   <= '0;
					big_s5[k] <= big_s4[k];
					r_s5[k]   <= r_s4[k];
				end else begin
					q_s5[k]   <= sat[k] ? '0 : rmag_s4[k][DW:0];
					big_s5[k] <= sat[k];
					r_s5[k]   <= '0;
				end
				n_s5[k] <= n_s4[k];
			end
			neg_s5 <= neg_s4;
			d_s5   <= d_s4;
		end
	end

	assign ctl_o = ctl_s5;
	assign d_o   = d_s5;
	assign r_o   = r_s5;
	assign n_o   = n_s5;
	assign q_o   = q_s5;
	assign neg_o = neg_s5;
	assign big_o = big_s5;

endmodule

`default_nettype wire

FILE: rtl/cau_div_cell.sv
`default_nettype none

module cau_div_cell #(
	parameter int DW = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire cau_pkg::ctl_t         ctl_i,
	input  wire logic [2*DW-1:0]       d_i,
	input  wire logic [1:0][2*DW:0]    r_i,
	input  wire logic [1:0][DW:0]      n_i,
	input  wire logic [1:0][DW:0]      q_i,
	input  wire logic [1:0]            neg_i,
	input  wire logic [1:0]            big_i,
	output cau_pkg::ctl_t              ctl_o,
	output logic [2*DW-1:0]            d_o,
	output logic [1:0][2*DW:0]         r_o,
	output logic [1:0][DW:0]           n_o,
	output logic [1:0][DW:0]           q_o,
	output logic [1:0]                 neg_o,
	output logic [1:0]                 big_o
);

	localparam int RW = 2 * DW + 1;

	cau_pkg::ctl_t      ctl_s1;
	logic [2*DW-1:0]    d_s1;
	logic [1:0][RW-1:0] r_s1;
	logic [1:0][DW:0]   n_s1;
	logic [1:0][DW:0]   q_s1;
	logic [1:0]         neg_s1;
	logic [1:0]         big_s1;

	logic [1:0][RW-1:0] r_sh;
	logic [1:0]         ge;
	logic [1:0][RW-1:0] r_nx;
	logic [1:0][DW:0]   n_nx;
	logic [1:0][DW:0]   q_nx;

	// one restoring step per part on a divide: shift in next dividend bit, trial subtract
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			r_sh[k] = {r_i[k][RW-2:0], n_i[k][DW]};
			ge[k]   = r_sh[k] >= {1'b0, d_i};
			if (ctl_i.op == cau_pkg::OP_DIV) begin
				r_nx[k] = ge[k] ? (r_sh[k] - {1'b0, d_i}) : r_sh[k];
				q_nx[k] = {q_i[k][DW-1:0], ge[k]};
				n_nx[k] = {n_i[k][DW-1:0], 1'b0};
			end else begin
				r_nx[k] = r_i[k];
				q_nx[k] = q_i[k];
				n_nx[k] = n_i[k];
			end
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
		end
	end

	// data
	always_ff @(posedge clk) begin
		if (en) begin
			d_s1   <= d_i;
			r_s1   <= r_nx;
			n_s1   <= n_nx;
			q_s1   <= q_nx;
			neg_s1 <= neg_i;
			big_s1 <= big_i;
		end
	end

	assign ctl_o = ctl_s1;
	assign d_o   = d_s1;
	assign r_o   = r_s1;
	assign n_o   = n_s1;
	assign q_o   = q_s1;
	assign neg_o = neg_s1;
	assign big_o = big_s1;

endmodule

`default_nettype wire

FILE: rtl/cau_back.sv
`default_nettype none

module cau_back #(
	parameter int DW = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire cau_pkg::ctl_t                ctl_i,
	input  wire logic [2*DW-1:0]              d_i,
	input  wire logic [1:0][2*DW:0]           r_i,
	input  wire logic [1:0][DW:0]             q_i,
	input  wire logic [1:0]                   neg_i,
	input  wire logic [1:0]                   big_i,
	output logic                              out_valid,
	output logic [cau_pkg::WORD_W-1:0]        res_real,
	output logic [cau_pkg::WORD_W-1:0]        res_imag,
	output logic                              overflow,
	output logic                              div_zero
);

	localparam int RW = 2 * DW + 1;
	localparam logic [DW+1:0] LIMN = (DW+2)'(1) << (DW - 1);
	localparam logic [DW+1:0] LIMP = LIMN - (DW+2)'(1);

	logic                              valid_q;
	logic [1:0][cau_pkg::WORD_W-1:0]   res_q;
	logic                              ovf_q;
	logic                              dz_q;

	logic [1:0]                        inc;
	logic [1:0][DW+1:0]                mag;
	logic [1:0][DW+1:0]                lim;
	logic [1:0]                        sat;
	logic [1:0][DW+1:0]                clamp;
	logic [1:0][DW-1:0]                word;

	// quotient rounding, then clamp to the output range
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			inc[k]   = (ctl_i.op == cau_pkg::OP_DIV) &&
			           ({r_i[k][RW-2:0], 1'b0} >= {1'b0, d_i});
			mag[k]   = (DW+2)'(q_i[k]) + (DW+2)'(inc[k]);
			lim[k]   = neg_i[k] ? LIMN : LIMP;
			sat[k]   = big_i[k] || (mag[k] > lim[k]);
			clamp[k] = sat[k] ? lim[k] : mag[k];
			word[k]  = neg_i[k] ? DW'((DW+2)'(0) - clamp[k]) : clamp[k][DW-1:0];
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= ctl_i.valid;
		end
	end

	// output beat
	always_ff @(posedge clk) begin
		if (en) begin
			if (ctl_i.dz) begin
				res_q <= '0;
				ovf_q <= 1'b0;
				dz_q  <= 1'b1;
			end else begin
				for (int k = 0; k < 2; k++) begin
					res_q[k] <= cau_pkg::WORD_W'($signed(word[k]));
				end
				ovf_q <= |sat;
				dz_q  <= 1'b0;
			end
		end
	end

	assign out_valid = valid_q;
	assign res_real  = res_q[0];
	assign res_imag  = res_q[1];
	assign overflow  = ovf_q;
	assign div_zero  = dz_q;

endmodule

`default_nettype wire

FILE: tb/cau_checker.sv
`timescale 1ns / 100ps
`default_nettype none

module cau_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [31:0] a_real,
	input  wire logic [31:0] a_imag,
	input  wire logic [31:0] b_real,
	input  wire logic [31:0] b_imag,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [31:0] res_real,
	input  wire logic [31:0] res_imag,
	input  wire logic        overflow,
	input  wire logic        div_zero,
	output int               errors,
	output int               pending
);

	typedef struct {
		logic [31:0] re;
		logic [31:0] im;
		logic        ovf;
		logic        dz;
	} cplx_res_t;

	typedef struct {
		bit          neg;
		logic [63:0] mag;
	} smag_t;

	cplx_res_t result_fifo[$];

	// signed value to sign and magnitude
	function automatic smag_t to_smag(input longint p);
		smag_t s;
		s.neg = p < 0;
		s.mag = s.neg ? 64'd0 - 64'(p) : 64'(p);
		return s;
	endfunction

	function automatic smag_t smag_sum(input smag_t x, input smag_t y);
		smag_t s;
		if (x.neg == y.neg) begin
			s.neg = x.neg;
			s.mag = x.mag + y.mag;
		end else if (x.mag >= y.mag) begin
			s.neg = x.neg;
			s.mag = x.mag - y.mag;
		end else begin
			s.neg = y.neg;
			s.mag = y.mag - x.mag;
		end
		if (s.mag == 0)
			s.neg = 1'b0;
		return s;
	endfunction

	function automatic smag_t smag_negate(input smag_t x);
		if (x.mag != 0)
			x.neg = !x.neg;
		return x;
	endfunction

	// clamp a signed magnitude to the word range
	function automatic logic [31:0] clamp_word(input bit neg, input logic [63:0] mag,
		input bit big, inout logic ovf);
		logic [63:0] lim;
		lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
		if (big || mag > lim) begin
			mag = lim;
			ovf = 1'b1;
		end
		return neg ? 32'(64'd0 - mag) : mag[31:0];
	endfunction

	// rounded num * 2^16 / den, big when far above range
	function automatic logic [63:0] quot_round(input logic [63:0] num, input logic [63:0] den,
		output bit big);
		logic [127:0] n, q, r;
		n = {64'd0, num} << 16;
		q = n / {64'd0, den};
		r = n % {64'd0, den};
		big = q >= (128'd1 << 63);
		return q[63:0] + ((r >= {64'd0, den} - r) ? 64'd1 : 64'd0);
	endfunction

	function automatic cplx_res_t predict_complex(input cau_pkg::op_t opc,
		input logic [31:0] war, input logic [31:0] wai, input logic [31:0] wbr,
		input logic [31:0] wbi);
		cplx_res_t e;
		longint ar, ai, br, bi;
		smag_t xr, xi;
		logic [63:0] d, q;
		bit big;
		ar = longint'(signed'(war));
		ai = longint'(signed'(wai));
		br = longint'(signed'(wbr));
		bi = longint'(signed'(wbi));
		e.re = '0;
		e.im = '0;
		e.ovf = 1'b0;
		e.dz = 1'b0;
		case (opc) inside
			cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
				xr = to_smag(opc == cau_pkg::OP_ADD ? ar + br : ar - br);
				xi = to_smag(opc == cau_pkg::OP_ADD ? ai + bi : ai - bi);
				e.re = clamp_word(xr.neg, xr.mag, 1'b0, e.ovf);
				e.im = clamp_word(xi.neg, xi.mag, 1'b0, e.ovf);
			end
			cau_pkg::OP_MUL: begin
				xr = smag_sum(to_smag(ar * br), smag_negate(to_smag(ai * bi)));
				xi = smag_sum(to_smag(ar * bi), to_smag(ai * br));
				e.re = clamp_word(xr.neg, (xr.mag + 64'h8000) >> 16, 1'b0, e.ovf);
				e.im = clamp_word(xi.neg, (xi.mag + 64'h8000) >> 16, 1'b0, e.ovf);
			end
			default: begin
				d = to_smag(br * br).mag + to_smag(bi * bi).mag;
				if (d == 0) begin
					e.dz = 1'b1;
				end else begin
					xr = smag_sum(to_smag(ar * br), to_smag(ai * bi));
					xi = smag_sum(to_smag(ai * br), smag_negate(to_smag(ar * bi)));
					q = quot_round(xr.mag, d, big);
					e.re = clamp_word(xr.neg && q != 0, q, big, e.ovf);
					q = quot_round(xi.mag, d, big);
					e.im = clamp_word(xi.neg && q != 0, q, big, e.ovf);
				end
			end
		endcase
		return e;
	endfunction

	assign pending = result_fifo.size();

	// predict on input beats, compare on output beats
	always @(posedge clk or negedge arst_n) begin
		cplx_res_t e;
		if (!arst_n) begin
			errors <= 0;
		end else begin
			if (in_valid && in_ready)
				result_fifo = {result_fifo, predict_complex(cau_pkg::op_t'(op),
					a_real, a_imag, b_real, b_imag)};
			if (out_valid && out_ready) begin
				if (result_fifo.size() == 0) begin
					if (errors < 10)
						$display("unexpected result beat: re=%h im=%h ovf=%b dz=%b",
							res_real, res_imag, overflow, div_zero);
					errors <= errors + 1;
				end else begin
					e = result_fifo.pop_front();
					if (e.re !== res_real || e.im !== res_imag || e.ovf !== overflow ||
						e.dz !== div_zero) begin
						if (errors < 10)
							$display({"mismatch: exp re=%h im=%h ovf=%b dz=%b ",
								"got re=%h im=%h ovf=%b dz=%b"},
								e.re, e.im, e.ovf, e.dz, res_real, res_imag, overflow,
								div_zero);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: tb/complex_arithmetic_unit_test.sv
`timescale 1ns / 100ps
`default_nettype none

module complex_arithmetic_unit_test;

	localparam int N_RANDOM = 800;
	localparam int CYCLE_LIMIT = 200000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  op = cau_pkg::OP_ADD;
	logic [31:0] a_real = '0, a_imag = '0, b_real = '0, b_imag = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] res_real, res_imag;
	logic        overflow, div_zero;
	logic        beat_taken = 1'b0;
	int          errors, pending;
	int          cycles = 0;
	int          gap_left = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	complex_arithmetic_unit dut (.*);

	cau_checker u_checker (.*);

	// input beat seen at the last rising edge
	always @(posedge clk)
		beat_taken <= in_valid && in_ready;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver stalls: phases of always ready, mostly ready and sparse
	always @(negedge clk) begin
		case ((cycles / 300) % 3)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			default: out_ready <= ($urandom_range(0, 4) == 0);
		endcase
	end

	function automatic logic [31:0] pick_operand();
		logic [31:0] v;
		case ($urandom_range(0, 5)) inside
			0: case ($urandom_range(0, 7))
				0: v = 32'h0000_0000;
				1: v = 32'h7fff_ffff;
				2: v = 32'h8000_0000;
				3: v = 32'hffff_ffff;
				4: v = 32'h0001_0000;
				5: v = 32'hffff_0000;
				6: v = 32'h0000_8000;
				default: v = 32'h0000_0001;
			endcase
			1, 2: v = 32'(signed'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
			3: v = 32'(signed'($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// drive one beat and hold it until taken
	task automatic send_beat(input cau_pkg::op_t o, input logic [31:0] ar,
		input logic [31:0] ai, input logic [31:0] br, input logic [31:0] bi);
		op = o;
		a_real = ar;
		a_imag = ai;
		b_real = br;
		b_imag = bi;
		in_valid = 1'b1;
		do @(negedge clk); while (!beat_taken);
	endtask

	task automatic send_gap(input int n);
		in_valid = 1'b0;
		repeat (n) @(negedge clk);
	endtask

	initial begin
		cau_pkg::op_t o;
		logic [31:0] br, bi;
		int burst;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes, each operation, zero divisor, rounding ties
		send_beat(cau_pkg::OP_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff);
		send_beat(cau_pkg::OP_ADD, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		send_beat(cau_pkg::OP_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff);
		send_beat(cau_pkg::OP_SUB, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0000_0000);
		send_beat(cau_pkg::OP_MUL, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
		send_beat(cau_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_beat(cau_pkg::OP_MUL, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
		send_beat(cau_pkg::OP_MUL, 32'h0000_0001, 32'h0000_0000, 32'h0000_8000, 32'h0000_0000);
		send_beat(cau_pkg::OP_MUL, 32'hffff_ffff, 32'h0000_0000, 32'h0000_8000, 32'h0000_0000);
		send_beat(cau_pkg::OP_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
		send_beat(cau_pkg::OP_DIV, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_beat(cau_pkg::OP_DIV, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'h0002_0000);
		send_beat(cau_pkg::OP_DIV, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0001, 32'h0000_0000);
		send_beat(cau_pkg::OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff);
		send_beat(cau_pkg::OP_DIV, 32'h0000_0001, 32'h0000_0000, 32'h0002_0000, 32'h0000_0000);
		send_beat(cau_pkg::OP_DIV, 32'hffff_ffff, 32'h0000_0000, 32'h0002_0000, 32'h0000_0000);
		send_beat(cau_pkg::OP_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
		send_beat(cau_pkg::OP_DIV, 32'h0001_0000, 32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000);
		send_gap(3);

		// random bursts
		for (int i = 0; i < N_RANDOM; i += burst) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst; k++) begin
				o = cau_pkg::op_t'($urandom_range(0, 3));
				br = pick_operand();
				bi = pick_operand();
				if (o == cau_pkg::OP_DIV && $urandom_range(0, 9) == 0) begin
					br = '0;
					bi = '0;
				end
				send_beat(o, pick_operand(), pick_operand(), br, bi);
			end
			if ($urandom_range(0, 2) != 0)
				send_gap($urandom_range(1, 12));
			// halfway through, hold off until the pipeline has drained
			if (i < N_RANDOM / 2 && i + burst >= N_RANDOM / 2) begin
				in_valid = 1'b0;
				while (pending != 0) @(negedge clk);
			end
		end

		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
